@@ rtl/smb_pkg.sv @@
// Shared types and constants for the serial bank mapper.
// No dependencies; used by every other file of the block but smb_out_if.
`default_nettype none

package smb_pkg;

  localparam int unsigned STAMP_W = 48;

  // register selects (address bits 14:13)
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // PRG modes, control bits 3:2
  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

  localparam logic [4:0] CTRL_RESET     = 5'h0C;
  localparam logic [4:0] CTRL_PRG_FORCE = 5'h0C;
  localparam logic [2:0] SHIFT_LAST     = 3'd4;
  localparam logic [STAMP_W:0] HOLDOFF  = (STAMP_W+1)'(2);

  // chip revisions
  localparam logic REV_A = 1'b0;
  localparam logic REV_B = 1'b1;

  // work RAM size codes
  localparam logic [1:0] WRAM_NONE = 2'd0;
  localparam logic [1:0] WRAM_8K   = 2'd1;
  localparam logic [1:0] WRAM_16K  = 2'd2;
  localparam logic [1:0] WRAM_32K  = 2'd3;

  // configuration register indexes
  localparam logic CFG_IDX_REVISION  = 1'b0;
  localparam logic CFG_IDX_WRAM_SIZE = 1'b1;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] prg;
  } smb_banks_t;

  typedef struct packed {
    logic [3:0] prg_bank_low;
    logic [3:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] mirroring;
    logic       wram_enabled;
    logic [1:0] wram_bank;
  } smb_map_t;

endpackage

`default_nettype wire

@@ rtl/smb_in_if.sv @@
// Write channel into the mapper: valid/ready plus one CPU write word.
// Depends on smb_pkg for the stamp width.
`default_nettype none

interface smb_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  register_select;
  logic [7:0]                  write_data;
  logic [smb_pkg::STAMP_W-1:0] cycle_stamp;

  modport source (output valid, register_select, write_data, cycle_stamp, input ready);
  modport sink   (input valid, register_select, write_data, cycle_stamp, output ready);
endinterface

`default_nettype wire

@@ rtl/smb_out_if.sv @@
// Result channel of the mapper: valid/ready plus the mapping word.
// No dependencies.
`default_nettype none

interface smb_out_if;
  logic       valid;
  logic       ready;
  logic       write_taken;
  logic [3:0] prg_bank_low;
  logic [3:0] prg_bank_high;
  logic [4:0] chr_bank_low;
  logic [4:0] chr_bank_high;
  logic [1:0] mirroring;
  logic       wram_enabled;
  logic [1:0] wram_bank;

  modport source (output valid, write_taken, prg_bank_low, prg_bank_high, chr_bank_low,
                  chr_bank_high, mirroring, wram_enabled, wram_bank, input ready);
  modport sink   (input valid, write_taken, prg_bank_low, prg_bank_high, chr_bank_low,
                  chr_bank_high, mirroring, wram_enabled, wram_bank, output ready);
endinterface

`default_nettype wire

@@ rtl/smb_regs.sv @@
// Serial load state: shift register, hold-off stamp and the four bank registers.
// Depends on smb_pkg; presents the post-write register values combinationally.
`default_nettype none

module smb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [1:0]                  register_select,
  input  wire logic [7:0]                  write_data,
  input  wire logic [smb_pkg::STAMP_W-1:0] cycle_stamp,
  output logic                             taken,
  output smb_pkg::smb_banks_t              banks_nxt
);

  smb_pkg::smb_banks_t         banks_r;
  logic [4:0]                  shift_buf_r, shift_buf_nxt, shift_fill;
  logic [2:0]                  shift_cnt_r, shift_cnt_nxt;
  logic [smb_pkg::STAMP_W-1:0] last_stamp_r, last_stamp_nxt;

  always_comb begin
    taken = {1'b0, cycle_stamp} >= ({1'b0, last_stamp_r} + smb_pkg::HOLDOFF);
    banks_nxt      = banks_r;
    shift_buf_nxt  = shift_buf_r;
    shift_cnt_nxt  = shift_cnt_r;
    last_stamp_nxt = last_stamp_r;
    shift_fill     = shift_buf_r | (5'(write_data[0]) << shift_cnt_r);
    if (taken) begin
      if (write_data[7]) begin
        banks_nxt.control = banks_r.control | smb_pkg::CTRL_PRG_FORCE;
        shift_buf_nxt  = '0;
        shift_cnt_nxt  = '0;
        last_stamp_nxt = cycle_stamp;
      end else if (shift_cnt_r == smb_pkg::SHIFT_LAST) begin
        case (register_select)
          smb_pkg::SEL_CONTROL: banks_nxt.control  = shift_fill;
          smb_pkg::SEL_CHR0:    banks_nxt.chr_low  = shift_fill;
          smb_pkg::SEL_CHR1:    banks_nxt.chr_high = shift_fill;
          default:              banks_nxt.prg      = shift_fill;
        endcase
        shift_buf_nxt = '0;
        shift_cnt_nxt = '0;
      end else begin
        shift_buf_nxt = shift_fill;
        shift_cnt_nxt = shift_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r.control  <= smb_pkg::CTRL_RESET;
      banks_r.chr_low  <= '0;
      banks_r.chr_high <= '0;
      banks_r.prg      <= '0;
      shift_buf_r      <= '0;
      shift_cnt_r      <= '0;
      last_stamp_r     <= '0;
    end else if (step) begin
      banks_r      <= banks_nxt;
      shift_buf_r  <= shift_buf_nxt;
      shift_cnt_r  <= shift_cnt_nxt;
      last_stamp_r <= last_stamp_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/smb_map.sv @@
// Bank decode: turns the four mapper registers and the board setup into a mapping.
// Depends on smb_pkg; purely combinational.
`default_nettype none

module smb_map (
  input  wire smb_pkg::smb_banks_t banks,
  input  wire logic                chip_revision,
  input  wire logic [1:0]          wram_size_code,
  output smb_pkg::smb_map_t        map
);

  logic [3:0] prg_lo, prg_hi;
  logic       prg_passthru;

  always_comb begin
    case (banks.control[3:2])
      smb_pkg::PRG_MODE_FIX_HIGH: begin
        prg_lo = banks.prg[3:0];
        prg_hi = banks.prg[3:0] | 4'hF;
      end
      smb_pkg::PRG_MODE_FIX_LOW: begin
        prg_lo = '0;
        prg_hi = banks.prg[3:0];
      end
      default: begin
        prg_lo = {banks.prg[3:1], 1'b0};
        prg_hi = {banks.prg[3:1], 1'b1};
      end
    endcase
    // rev A: PRG bit 4 lets bit 3 through unchanged
    prg_passthru = banks.prg[4] && (chip_revision == smb_pkg::REV_A);
    map.prg_bank_low  = prg_passthru ? {banks.prg[3], prg_lo[2:0]} : prg_lo;
    map.prg_bank_high = prg_passthru ? {banks.prg[3], prg_hi[2:0]} : prg_hi;

    if (banks.control[4]) begin
      map.chr_bank_low  = banks.chr_low;
      map.chr_bank_high = banks.chr_high;
    end else begin
      map.chr_bank_low  = {banks.chr_low[4:1], 1'b0};
      map.chr_bank_high = {banks.chr_low[4:1], 1'b1};
    end

    map.mirroring = banks.control[1:0];

    map.wram_enabled = (wram_size_code != smb_pkg::WRAM_NONE) &&
                       !(banks.prg[4] && (chip_revision == smb_pkg::REV_B));
    case (wram_size_code)
      smb_pkg::WRAM_32K: map.wram_bank = banks.chr_low[3:2];
      smb_pkg::WRAM_16K: map.wram_bank = {1'b0, banks.chr_low[3]};
      default:           map.wram_bank = 2'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/serial_bank_mapper_top.sv @@
// Top level of the serial bank mapper: input register, state update, result register.
// Depends on smb_pkg, smb_in_if, smb_out_if, smb_regs and smb_map.
`default_nettype none

// Serially loaded cartridge bank mapper (revisions A and B). Each word on in_word
// is one CPU write to the mapper range with its cycle stamp; each produces exactly
// one out_word holding write_taken and the full mapping after the write. One word
// per clock is sustained while out_word.ready stays high: a word waits in the input
// register, and the state update plus bank decode run between that register and the
// result register; out_word.valid rises as the word moves into the result register.
// The result register lets a new word enter while a result waits. Board setup
// (cfg_index 0 chip revision, 1 work RAM size) is written on cfg_we and must only
// change while no word is in flight.
module serial_bank_mapper_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  smb_in_if.sink          in_word,
  smb_out_if.source       out_word,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_data
);

  logic                        in_valid_r;
  logic [1:0]                  in_sel_r;
  logic [7:0]                  in_data_r;
  logic [smb_pkg::STAMP_W-1:0] in_stamp_r;

  logic                        out_valid_r;
  logic                        out_taken_r;
  smb_pkg::smb_map_t           out_map_r;

  logic                        chip_revision_r;
  logic [1:0]                  wram_size_r;

  logic                        advance;
  logic                        taken;
  smb_pkg::smb_banks_t         banks_nxt;
  smb_pkg::smb_map_t           map_nxt;

  assign advance       = in_valid_r && (!out_valid_r || out_word.ready);
  assign in_word.ready = !in_valid_r || advance;

  smb_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .register_select (in_sel_r),
    .write_data      (in_data_r),
    .cycle_stamp     (in_stamp_r),
    .taken           (taken),
    .banks_nxt       (banks_nxt)
  );

  smb_map u_map (
    .banks          (banks_nxt),
    .chip_revision  (chip_revision_r),
    .wram_size_code (wram_size_r),
    .map            (map_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_revision_r <= smb_pkg::REV_B;
      wram_size_r     <= smb_pkg::WRAM_8K;
    end else if (cfg_we) begin
      case (cfg_index)
        smb_pkg::CFG_IDX_REVISION:  chip_revision_r <= cfg_data[0];
        smb_pkg::CFG_IDX_WRAM_SIZE: wram_size_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      in_valid_r <= in_word.valid;
    end
    if (in_word.valid && in_word.ready) begin
      in_sel_r   <= in_word.register_select;
      in_data_r  <= in_word.write_data;
      in_stamp_r <= in_word.cycle_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_taken_r <= taken;
      out_map_r   <= map_nxt;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.write_taken   = out_taken_r;
  assign out_word.prg_bank_low  = out_map_r.prg_bank_low;
  assign out_word.prg_bank_high = out_map_r.prg_bank_high;
  assign out_word.chr_bank_low  = out_map_r.chr_bank_low;
  assign out_word.chr_bank_high = out_map_r.chr_bank_high;
  assign out_word.mirroring     = out_map_r.mirroring;
  assign out_word.wram_enabled  = out_map_r.wram_enabled;
  assign out_word.wram_bank     = out_map_r.wram_bank;

endmodule

`default_nettype wire

@@ verif/smb_mapping_compare.sv @@
`timescale 1ns / 1ps
// Mapping predictor and result compare for serial_bank_mapper_top.
// Watches the write channel, setup port and mapping channel; needs smb_pkg and both channel ifs.

module smb_mapping_compare (
  input  logic       clk,
  input  logic       rst_n,
  smb_in_if          wr_mon,
  smb_out_if         map_mon,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  output int         mismatches,
  output int         in_flight,
  output int         maps_seen,
  output int         writes_ignored
);
  import smb_pkg::*;

  typedef struct packed {
    logic     taken;
    smb_map_t map;
  } map_word_t;

  map_word_t          pending_maps[$];
  logic               rev_r;
  logic [1:0]         wram_size_r;
  logic [4:0]         ctrl_r;
  logic [4:0]         chr0_r;
  logic [4:0]         chr1_r;
  logic [4:0]         prg_r;
  logic [4:0]         shift_bits;
  logic [2:0]         shift_pos;
  logic [STAMP_W-1:0] reset_stamp_r;
  int                 fail_n = 0;
  int                 seen_n = 0;
  int                 ignored_n = 0;

  function automatic logic [3:0] prg_window(logic upper);
    logic [3:0] bank;
    case (ctrl_r[3:2])
      PRG_MODE_FIX_HIGH: bank = upper ? 4'hF : prg_r[3:0];
      PRG_MODE_FIX_LOW:  bank = upper ? prg_r[3:0] : 4'h0;
      default:           bank = {prg_r[3:1], upper};
    endcase
    // rev A: PRG bit 4 lets bit 3 through unchanged
    if (prg_r[4] && rev_r == REV_A) bank[3] = prg_r[3];
    return bank;
  endfunction

  function automatic smb_map_t current_map();
    smb_map_t m;
    m.prg_bank_low  = prg_window(1'b0);
    m.prg_bank_high = prg_window(1'b1);
    m.chr_bank_low  = ctrl_r[4] ? chr0_r : {chr0_r[4:1], 1'b0};
    m.chr_bank_high = ctrl_r[4] ? chr1_r : {chr0_r[4:1], 1'b1};
    m.mirroring     = ctrl_r[1:0];
    m.wram_enabled  = (wram_size_r != WRAM_NONE) && !(prg_r[4] && rev_r == REV_B);
    case (wram_size_r)
      WRAM_32K: m.wram_bank = chr0_r[3:2];
      WRAM_16K: m.wram_bank = {1'b0, chr0_r[3]};
      default:  m.wram_bank = 2'd0;
    endcase
    return m;
  endfunction

  function automatic map_word_t apply_write(logic [1:0] sel, logic [7:0] data,
                                            logic [STAMP_W-1:0] stamp);
    map_word_t r;
    r.taken = ({1'b0, stamp} >= ({1'b0, reset_stamp_r} + HOLDOFF));
    if (r.taken) begin
      if (data[7]) begin
        ctrl_r        = ctrl_r | CTRL_PRG_FORCE;
        shift_bits    = '0;
        shift_pos     = '0;
        reset_stamp_r = stamp;
      end else begin
        shift_bits[shift_pos] = data[0];
        if (shift_pos == SHIFT_LAST) begin
          case (sel)
            SEL_CONTROL: ctrl_r = shift_bits;
            SEL_CHR0:    chr0_r = shift_bits;
            SEL_CHR1:    chr1_r = shift_bits;
            default:     prg_r  = shift_bits;
          endcase
          shift_bits = '0;
          shift_pos  = '0;
        end else begin
          shift_pos = shift_pos + 3'd1;
        end
      end
    end
    r.map = current_map();
    return r;
  endfunction

  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want != got)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return want == got;
  endfunction

  always @(posedge clk) begin
    map_word_t want;
    map_word_t got;
    bit        ok;
    if (!rst_n) begin
      rev_r         = REV_B;
      wram_size_r   = WRAM_8K;
      ctrl_r        = CTRL_RESET;
      chr0_r        = '0;
      chr1_r        = '0;
      prg_r         = '0;
      shift_bits    = '0;
      shift_pos     = '0;
      reset_stamp_r = '0;
      pending_maps.delete();
    end else begin
      if (map_mon.valid && map_mon.ready) begin
        got.taken             = map_mon.write_taken;
        got.map.prg_bank_low  = map_mon.prg_bank_low;
        got.map.prg_bank_high = map_mon.prg_bank_high;
        got.map.chr_bank_low  = map_mon.chr_bank_low;
        got.map.chr_bank_high = map_mon.chr_bank_high;
        got.map.mirroring     = map_mon.mirroring;
        got.map.wram_enabled  = map_mon.wram_enabled;
        got.map.wram_bank     = map_mon.wram_bank;
        seen_n++;
        if (pending_maps.size() == 0) begin
          $display("%0t: mapping word with no write pending, expected none, actual %h",
                   $time, got);
          fail_n++;
        end else begin
          want = pending_maps.pop_front();
          ok = 1'b1;
          ok = field_ok("write_taken", want.taken, got.taken) & ok;
          ok = field_ok("prg_bank_low", want.map.prg_bank_low, got.map.prg_bank_low) & ok;
          ok = field_ok("prg_bank_high", want.map.prg_bank_high, got.map.prg_bank_high) & ok;
          ok = field_ok("chr_bank_low", want.map.chr_bank_low, got.map.chr_bank_low) & ok;
          ok = field_ok("chr_bank_high", want.map.chr_bank_high, got.map.chr_bank_high) & ok;
          ok = field_ok("mirroring", want.map.mirroring, got.map.mirroring) & ok;
          ok = field_ok("wram_enabled", want.map.wram_enabled, got.map.wram_enabled) & ok;
          ok = field_ok("wram_bank", want.map.wram_bank, got.map.wram_bank) & ok;
          if (!ok) fail_n++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_REVISION) rev_r = cfg_data[0];
        else wram_size_r = cfg_data;
      end
      if (wr_mon.valid && wr_mon.ready) begin
        want = apply_write(wr_mon.register_select, wr_mon.write_data, wr_mon.cycle_stamp);
        if (!want.taken) ignored_n++;
        pending_maps.push_back(want);
      end
    end
    mismatches     <= fail_n;
    in_flight      <= pending_maps.size();
    maps_seen      <= seen_n;
    writes_ignored <= ignored_n;
  end

endmodule

@@ verif/tb_serial_bank_mapper_top.sv @@
`timescale 1ns / 1ps
// Testbench top for serial_bank_mapper_top: clock, reset, write stimulus, result stalls, verdict.
// Needs smb_pkg, smb_in_if, smb_out_if, the block itself and smb_mapping_compare.

module tb_serial_bank_mapper_top;
  import smb_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [1:0]         cfg_data;
  int                 mismatches;
  int                 in_flight;
  int                 maps_seen;
  int                 writes_ignored;
  int                 words_sent = 0;
  int                 setups = 0;
  int                 rx_hold = 0;
  bit                 tx_burst = 1'b0;
  bit                 rx_burst = 1'b0;
  logic [STAMP_W-1:0] now = '0;

  smb_in_if  in_word();
  smb_out_if out_word();

  serial_bank_mapper_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  smb_mapping_compare i_compare (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_mon        (in_word),
    .map_mon       (out_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .in_flight     (in_flight),
    .maps_seen     (maps_seen),
    .writes_ignored(writes_ignored)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d mapping words still outstanding", $time, in_flight);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [STAMP_W-1:0] tick();
    now = now + STAMP_W'($urandom_range(0, 3));
    return now;
  endfunction

  task automatic send_word(input logic [1:0] sel, input logic [7:0] data,
                           input logic [STAMP_W-1:0] stamp);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid           <= 1'b1;
    in_word.register_select <= sel;
    in_word.write_data      <= data;
    in_word.cycle_stamp     <= stamp;
    do @(posedge clk); while (!in_word.ready);
    words_sent++;
  endtask

  task automatic load_reg(input logic [1:0] sel, input logic [4:0] value, input bit far_first);
    for (int i = 0; i < 5; i++)
      send_word(sel, {1'b0, 6'($urandom_range(0, 63)), value[i]},
                (far_first && i == 0) ? {STAMP_W{1'b1}} : tick());
  endtask

  // five serial words to one register, now and then broken by a reset word
  task automatic random_load();
    logic [1:0] sel;
    sel = 2'($urandom_range(0, 3));
    for (int i = 0; i < 5; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_word(sel, 8'h80 | 8'($urandom_range(0, 127)), tick());
      else
        send_word(sel, {1'b0, 7'($urandom_range(0, 127))}, tick());
    end
  endtask

  task automatic drain();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic board_setup(input logic rev, input logic [1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_REVISION;
    cfg_data  <= {1'b0, rev};
    @(posedge clk);
    cfg_index <= CFG_IDX_WRAM_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    setups++;
  endtask

  initial begin
    int kind;
    int phase_end;
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_IDX_REVISION;
    cfg_data                <= 2'd0;
    in_word.valid           <= 1'b0;
    in_word.register_select <= SEL_CONTROL;
    in_word.write_data      <= 8'h00;
    in_word.cycle_stamp     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults, hold-off at stamps 0 and 1, field extremes
    send_word(SEL_CONTROL, 8'h00, '0);
    send_word(SEL_PRG, 8'hFF, STAMP_W'(1));
    now = STAMP_W'(2);
    load_reg(SEL_PRG, 5'h1F, 1'b0);
    load_reg(SEL_CHR0, 5'h15, 1'b0);
    load_reg(SEL_CONTROL, 5'h13, 1'b1);
    send_word(SEL_CHR0, 8'hFF, tick());
    send_word(SEL_CHR1, 8'h80, now + STAMP_W'(1));
    now = now + STAMP_W'(2);
    load_reg(SEL_CHR1, 5'h0A, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       board_setup(REV_A, WRAM_NONE);
        1:       board_setup(REV_B, WRAM_32K);
        2:       board_setup(REV_A, WRAM_16K);
        3:       board_setup(REV_B, WRAM_8K);
        4:       board_setup(REV_A, WRAM_32K);
        default: board_setup(REV_B, WRAM_16K);
      endcase
      if (phase == 1) begin
        // receiver goes quiet while words keep coming back to back
        tx_burst = 1'b1;
        rx_hold  = 300;
        repeat (8) random_load();
        tx_burst = 1'b0;
        drain();
      end
      phase_end = words_sent + 200;
      while (words_sent < phase_end) begin
        tx_burst = ($urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          random_load();
        end else if (kind < 82) begin
          send_word(2'($urandom_range(0, 3)), 8'h80 | 8'($urandom_range(0, 127)), tick());
        end else if (kind < 94) begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), tick());
        end else if (kind < 97) begin
          send_word(2'($urandom_range(0, 3)), {1'b0, 7'($urandom_range(0, 127))},
                    {16'($urandom), 32'($urandom)});
        end else begin
          now = now + STAMP_W'($urandom);
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), tick());
        end
      end
      tx_burst = 1'b0;
      drain();
    end

    // reset word at the top of the stamp range: nothing after it can be taken
    send_word(SEL_PRG, 8'hFF, {STAMP_W{1'b1}} - STAMP_W'(1));
    send_word(SEL_PRG, 8'h01, {STAMP_W{1'b1}});
    send_word(SEL_CONTROL, 8'hFF, {STAMP_W{1'b1}});
    drain();

    $display("Run covered %0d CPU writes (%0d held off) over %0d board setups,",
             words_sent, writes_ignored, setups);
    $display("with %0d mapping words compared against the predicted mapping.", maps_seen);
    if (mismatches == 0 && in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    out_word.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_word.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_word.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_word.ready <= 1'b1;
      do @(posedge clk); while (!out_word.valid);
    end
  end

endmodule

@@ files.f @@
rtl/smb_pkg.sv
rtl/smb_in_if.sv
rtl/smb_out_if.sv
rtl/smb_regs.sv
rtl/smb_map.sv
rtl/serial_bank_mapper_top.sv
verif/smb_mapping_compare.sv
verif/tb_serial_bank_mapper_top.sv
